// File: rtl/tpt_pkg.sv
// Package for the TLB / page table core: widths, state codes, register
// indexes and the TLB command struct. No dependencies.
package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int TLB_IDX_W   = 4;
  localparam int PAGE_W      = 8;
  localparam int FRAME_W     = 8;
  localparam int OFFSET_W    = 8;
  localparam int FCNT_W      = 9;
  localparam int STAMP_W     = 32;
  localparam int DEPTH       = 256;
  localparam logic [FCNT_W-1:0] MAX_FRAMES = 9'd256;

  localparam logic [1:0] REG_FRAMES_IN_USE  = 2'd0;
  localparam logic [1:0] REG_REPLACE_POLICY = 2'd1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOOK   = 8'b0000_0010,
    ST_PTRD   = 8'b0000_0100,
    ST_FIFORD = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_OWNRD  = 8'b0010_0000,
    ST_EVICT  = 8'b0100_0000,
    ST_COMMIT = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic               fill;
    logic               invalidate;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  victim;
  } tlb_cmd_t;

endpackage

// File: rtl/tpt_tlb.sv
// Fully associative TLB in flip-flops with round-robin refill.
// Depends on tpt_pkg.
module tpt_tlb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tpt_pkg::PAGE_W-1:0]    lookup_page,
  input  tpt_pkg::tlb_cmd_t             cmd,
  output logic                          hit,
  output logic [tpt_pkg::FRAME_W-1:0]   hit_frame
);

  logic [tpt_pkg::PAGE_W-1:0]    tag   [tpt_pkg::TLB_ENTRIES];
  logic [tpt_pkg::FRAME_W-1:0]   frm   [tpt_pkg::TLB_ENTRIES];
  logic [tpt_pkg::TLB_ENTRIES-1:0] vld;
  logic [tpt_pkg::TLB_ENTRIES-1:0] vld_next;
  logic [tpt_pkg::TLB_IDX_W-1:0] ptr;

  // Lowest matching entry wins.
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = tpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (vld[i] && tag[i] == lookup_page) begin
        hit       = 1'b1;
        hit_frame = frm[i];
      end
    end
  end

  // Drop the victim's entry first; a refill into the same slot wins.
  always_comb begin
    vld_next = vld;
    for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++) begin
      if (cmd.invalidate && vld[i] && tag[i] == cmd.victim) vld_next[i] = 1'b0;
    end
    if (cmd.fill) vld_next[ptr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      ptr <= '0;
    end else begin
      vld <= vld_next;
      if (cmd.fill) ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      tag[ptr] <= cmd.page;
      frm[ptr] <= cmd.frame;
    end
  end

endmodule

// File: rtl/tlb_page_table_with_replacement_core.sv
// Top level of the address translation core: TLB, page table, frame
// allocation with FIFO or LRU replacement. Depends on tpt_pkg and tpt_tlb.
//
// One virtual address enters per item and one translation leaves. A TLB hit
// goes from lookup straight to commit; a TLB miss with the page present, or a
// fault into a free frame, adds a page table read; a FIFO eviction also reads
// the FIFO order, then the frame owner; an LRU eviction scans the frame
// timestamp memory at one entry per cycle up to the clamped frame count, then
// reads the frame owner. Input is ready again when the result is presented.
// One item is in work at a time; the result register lets the next item enter
// while a result waits, and an item finishing while the previous result still
// waits holds in commit. The page frame, frame owner, FIFO order and
// timestamp tables sit in synchronous memories with one read and one write
// port; presence and timestamp valid bits are flip-flops cleared by reset,
// so no clearing pass is needed.
module tlb_page_table_with_replacement_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] virtual_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  phys_frame,
  output logic [15:0] physical_address,
  output logic        tlb_hit,
  output logic        page_fault,
  output logic        evicted,
  output logic [7:0]  evicted_page
);

  localparam int DEPTH = tpt_pkg::DEPTH;

  // configuration
  logic [tpt_pkg::FCNT_W-1:0] frames_in_use;
  logic                       replace_policy;

  // control and item state
  tpt_pkg::state_t state;
  logic [7:0] page_q, offset_q, frame_q, victim_q;
  logic [tpt_pkg::FCNT_W-1:0] n_q;
  logic hit_q, fault_q, evict_q;
  logic [tpt_pkg::FCNT_W-1:0] frames_filled;
  logic [7:0] rp, wp;
  logic [tpt_pkg::STAMP_W-1:0] access_count;

  // memories
  logic [7:0]  pf_mem    [DEPTH];
  logic [7:0]  owner_mem [DEPTH];
  logic [7:0]  fifo_mem  [DEPTH];
  logic [31:0] lru_mem   [DEPTH];
  logic [7:0]  pf_rdata, owner_rdata, fifo_rdata;
  logic [31:0] lru_rdata;
  logic        lru_rvld;
  logic [DEPTH-1:0] present;
  logic [DEPTH-1:0] present_next;
  logic [DEPTH-1:0] lru_valid;

  // LRU scan
  logic [7:0]  scan_addr, cmp_idx, best;
  logic        cmp_go;
  logic [31:0] best_t, cmp_t;
  logic        take;
  logic        scan_last;

  logic [7:0] rp_eff, wp_eff;
  logic [tpt_pkg::FCNT_W-1:0] n_cfg;
  logic commit_go;

  logic tlb_lk_hit;
  logic [7:0] tlb_lk_frame;
  tpt_pkg::tlb_cmd_t tlb_cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == tpt_pkg::ST_IDLE);
  assign commit_go = (state == tpt_pkg::ST_COMMIT) && (!out_valid || out_ready);

  // Clamp the frame count into 1..MAX_FRAMES.
  always_comb begin
    if (frames_in_use == '0) n_cfg = 9'd1;
    else if (frames_in_use > tpt_pkg::MAX_FRAMES) n_cfg = tpt_pkg::MAX_FRAMES;
    else n_cfg = frames_in_use;
  end

  // FIFO pointers wrap to 0 when not below the current count.
  assign rp_eff = ({1'b0, rp} >= n_q) ? 8'd0 : rp;
  assign wp_eff = ({1'b0, wp} >= n_q) ? 8'd0 : wp;

  assign cmp_t     = lru_rvld ? lru_rdata : '0;
  assign take      = (cmp_idx == 8'd0) || (cmp_t < best_t);
  assign scan_last = ({1'b0, cmp_idx} == n_q - 9'd1);

  // Presence update at commit: drop the victim page, mark the new page.
  always_comb begin
    present_next = present;
    if (commit_go && evict_q) present_next[victim_q] = 1'b0;
    if (commit_go && fault_q) present_next[page_q] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use  <= tpt_pkg::MAX_FRAMES;
      replace_policy <= tpt_pkg::POLICY_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpt_pkg::REG_FRAMES_IN_USE:  frames_in_use  <= cfg_data;
        tpt_pkg::REG_REPLACE_POLICY: replace_policy <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tpt_tlb u_tlb (
    .clk        (clk),
    .rst        (rst),
    .lookup_page(page_q),
    .cmd        (tlb_cmd),
    .hit        (tlb_lk_hit),
    .hit_frame  (tlb_lk_frame)
  );

  // Refill on every miss; drop the victim page's entry on eviction.
  always_comb begin
    tlb_cmd.fill       = commit_go && !hit_q;
    tlb_cmd.invalidate = commit_go && evict_q;
    tlb_cmd.page       = page_q;
    tlb_cmd.frame      = frame_q;
    tlb_cmd.victim     = victim_q;
  end

  // Memory reads: addresses held by the controller, read data registered.
  always_ff @(posedge clk) begin
    pf_rdata    <= pf_mem[page_q];
    owner_rdata <= owner_mem[frame_q];
    fifo_rdata  <= fifo_mem[rp_eff];
    lru_rdata   <= lru_mem[scan_addr];
    lru_rvld    <= lru_valid[scan_addr];
  end

  // Memory writes at commit.
  always_ff @(posedge clk) begin
    if (commit_go) begin
      lru_mem[frame_q] <= access_count;
      if (fault_q) begin
        owner_mem[frame_q] <= page_q;
        pf_mem[page_q]     <= frame_q;
        if (replace_policy == tpt_pkg::POLICY_FIFO) fifo_mem[wp_eff] <= frame_q;
      end
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tpt_pkg::ST_IDLE;
      out_valid     <= 1'b0;
      present       <= '0;
      lru_valid     <= '0;
      frames_filled <= '0;
      rp            <= '0;
      wp            <= '0;
      access_count  <= '0;
      cmp_go        <= 1'b0;
    end else begin
      present <= present_next;
      if (commit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        tpt_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            page_q   <= virtual_address[15:8];
            offset_q <= virtual_address[7:0];
            n_q      <= n_cfg;
            hit_q    <= 1'b0;
            fault_q  <= 1'b0;
            evict_q  <= 1'b0;
            victim_q <= '0;
            state    <= tpt_pkg::ST_LOOK;
          end
        end
        tpt_pkg::ST_LOOK: begin
          if (tlb_lk_hit) begin
            hit_q   <= 1'b1;
            frame_q <= tlb_lk_frame;
            state   <= tpt_pkg::ST_COMMIT;
          end else begin
            state <= tpt_pkg::ST_PTRD;
          end
        end
        tpt_pkg::ST_PTRD: begin
          if (present[page_q]) begin
            frame_q <= pf_rdata;
            state   <= tpt_pkg::ST_COMMIT;
          end else begin
            fault_q <= 1'b1;
            if (frames_filled < n_q) begin
              frame_q       <= frames_filled[7:0];
              frames_filled <= frames_filled + 1'b1;
              state         <= tpt_pkg::ST_COMMIT;
            end else if (replace_policy == tpt_pkg::POLICY_FIFO) begin
              // fifo_rdata at the next edge holds the entry at rp_eff
              rp    <= ({1'b0, rp_eff} + 9'd1 >= n_q) ? 8'd0 : rp_eff + 8'd1;
              state <= tpt_pkg::ST_FIFORD;
            end else begin
              scan_addr <= '0;
              cmp_go    <= 1'b0;
              state     <= tpt_pkg::ST_SCAN;
            end
          end
        end
        tpt_pkg::ST_FIFORD: begin
          frame_q <= fifo_rdata;
          state   <= tpt_pkg::ST_OWNRD;
        end
        tpt_pkg::ST_SCAN: begin
          scan_addr <= scan_addr + 8'd1;
          cmp_idx   <= scan_addr;
          cmp_go    <= !(cmp_go && scan_last);
          if (cmp_go) begin
            if (take) begin
              best   <= cmp_idx;
              best_t <= cmp_t;
            end
            if (scan_last) begin
              frame_q <= take ? cmp_idx : best;
              state   <= tpt_pkg::ST_OWNRD;
            end
          end
        end
        tpt_pkg::ST_OWNRD: begin
          state <= tpt_pkg::ST_EVICT;
        end
        tpt_pkg::ST_EVICT: begin
          victim_q <= owner_rdata;
          evict_q  <= 1'b1;
          state    <= tpt_pkg::ST_COMMIT;
        end
        tpt_pkg::ST_COMMIT: begin
          if (commit_go) begin
            if (fault_q) begin
              if (replace_policy == tpt_pkg::POLICY_FIFO) begin
                wp <= ({1'b0, wp_eff} + 9'd1 >= n_q) ? 8'd0 : wp_eff + 8'd1;
              end
            end
            lru_valid[frame_q] <= 1'b1;
            if (access_count != '1) access_count <= access_count + 1'b1;
            phys_frame       <= frame_q;
            physical_address <= {frame_q, offset_q};
            tlb_hit          <= hit_q;
            page_fault       <= fault_q;
            evicted          <= evict_q;
            evicted_page     <= evict_q ? victim_q : 8'd0;
            state            <= tpt_pkg::ST_IDLE;
          end
        end
        default: state <= tpt_pkg::ST_IDLE;
      endcase
    end
  end

  // An eviction happens only on a fault, and a TLB hit never faults.
  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!evicted || page_fault)) else $error("eviction without fault");
  a_hit_nofault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault)) else $error("hit with fault");
  a_filled_max: assert property (@(posedge clk) disable iff (rst)
    frames_filled <= tpt_pkg::MAX_FRAMES) else $error("fill count overflow");
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == tpt_pkg::ST_LOOK) else $error("accept lost");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tpt_pkg::ST_SCAN && cmp_go) |-> {1'b0, cmp_idx} < n_q)
    else $error("scan past frame count");

endmodule
